FILE: rtl/mfb_pkg.sv
// Shared types and constants for the monochrome framebuffer blit/refresh block.
// Used by mfb_ctrl, mfb_datapath and mono_framebuffer_blit_refresh_top.
package mfb_pkg;

   localparam int SCREEN_WIDTH  = 128;
   localparam int SCREEN_HEIGHT = 64;
   localparam int FB_BYTES      = (SCREEN_WIDTH * SCREEN_HEIGHT) / 8;
   localparam int FB_ADDR_W     = $clog2(FB_BYTES);
   localparam int PAGE_COUNT    = SCREEN_HEIGHT / 8;
   localparam int PAGE_W        = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int HDR_LEN       = 3;
   localparam int PAGE_LEN      = HDR_LEN + SCREEN_WIDTH;
   localparam int COL_W         = $clog2(PAGE_LEN);
   localparam int X_W           = 7;
   localparam int CSR_IDX_W     = 2;

   // position of each command byte within a page
   localparam int HDR_PAGE = 0;
   localparam int HDR_LOW  = 1;
   localparam int HDR_HIGH = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_COL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_COL = 2'd2;

   localparam logic [7:0] PAGE_BASE_RST = 8'd176;
   localparam logic [7:0] LOWER_COL_RST = 8'd0;
   localparam logic [7:0] UPPER_COL_RST = 8'd16;

   // result kinds
   localparam logic KIND_PIXEL   = 1'b0;
   localparam logic KIND_REFRESH = 1'b1;

   typedef enum logic [2:0] {
      CMD_SET_PIXEL  = 3'd0,
      CMD_GET_PIXEL  = 3'd1,
      CMD_FILL       = 3'd2,
      CMD_BLIT_START = 3'd3,
      CMD_BLIT_BYTE  = 3'd4,
      CMD_RENDER     = 3'd5
   } cmd_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [6:0] x_pos;
      logic [5:0] y_pos;
      logic       pixel_value;
      logic [7:0] blit_w;
      logic [6:0] blit_h;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic       pixel_out;
      logic [7:0] spi_byte;
      logic       is_data;
      logic       frame_end;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SET_RD,
      ST_SET_WR,
      ST_GET_RD,
      ST_GET_OUT,
      ST_FILL,
      ST_BLIT_LOAD,
      ST_BLIT_RD,
      ST_BLIT_WR,
      ST_REF_RD,
      ST_REF_OUT
   } state_type;

   typedef enum logic [1:0] {
      RD_PIXEL,
      RD_BLIT,
      RD_REFRESH
   } rd_src_type;

   typedef struct packed {
      logic       req_load;
      rd_src_type rd_src;
      logic       pix_we;
      logic       blit_load;
      logic       blit_we;
      logic       sweep_we;
      logic       sweep_fill;
      logic       get_rsp;
      logic       ref_rsp;
   } ctl_type;

   typedef struct packed {
      logic sweep_last;
      logic blit_active;
      logic blit_stop;
   } sts_type;

endpackage

FILE: rtl/mfb_ctrl.sv
// Control state machine: sequences pixel, fill, blit and refresh operations.
// Depends on mfb_pkg; drives mfb_datapath through ctl_type commands.
module mfb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [2:0]        req_cmd,
   input  mfb_pkg::sts_type  sts,
   output logic              busy,
   output mfb_pkg::ctl_type  ctl
);

   mfb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfb_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mfb_pkg::ST_CLEAR: begin
            if (sts.sweep_last) state_in = mfb_pkg::ST_IDLE;
         end
         mfb_pkg::ST_IDLE: begin
            if (start) begin
               case (mfb_pkg::cmd_type'(req_cmd))
                  mfb_pkg::CMD_SET_PIXEL:  state_in = mfb_pkg::ST_SET_RD;
                  mfb_pkg::CMD_GET_PIXEL:  state_in = mfb_pkg::ST_GET_RD;
                  mfb_pkg::CMD_FILL:       state_in = mfb_pkg::ST_FILL;
                  mfb_pkg::CMD_BLIT_START: state_in = mfb_pkg::ST_BLIT_LOAD;
                  mfb_pkg::CMD_BLIT_BYTE: begin
                     state_in = sts.blit_active ? mfb_pkg::ST_BLIT_RD : mfb_pkg::ST_IDLE;
                  end
                  mfb_pkg::CMD_RENDER:     state_in = mfb_pkg::ST_REF_RD;
                  default:                 state_in = mfb_pkg::ST_IDLE;
               endcase
            end
         end
         mfb_pkg::ST_SET_RD:    state_in = mfb_pkg::ST_SET_WR;
         mfb_pkg::ST_SET_WR:    state_in = mfb_pkg::ST_IDLE;
         mfb_pkg::ST_GET_RD:    state_in = mfb_pkg::ST_GET_OUT;
         mfb_pkg::ST_GET_OUT:   state_in = mfb_pkg::ST_IDLE;
         mfb_pkg::ST_FILL: begin
            if (sts.sweep_last) state_in = mfb_pkg::ST_IDLE;
         end
         mfb_pkg::ST_BLIT_LOAD: state_in = mfb_pkg::ST_IDLE;
         mfb_pkg::ST_BLIT_RD:   state_in = mfb_pkg::ST_BLIT_WR;
         mfb_pkg::ST_BLIT_WR: begin
            state_in = sts.blit_stop ? mfb_pkg::ST_IDLE : mfb_pkg::ST_BLIT_RD;
         end
         mfb_pkg::ST_REF_RD:    state_in = mfb_pkg::ST_REF_OUT;
         mfb_pkg::ST_REF_OUT:   state_in = mfb_pkg::ST_IDLE;
         default:               state_in = mfb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      busy           = (state_ff != mfb_pkg::ST_IDLE);
      ctl            = '0;
      ctl.rd_src     = mfb_pkg::RD_PIXEL;
      ctl.req_load   = (state_ff == mfb_pkg::ST_IDLE) && start;
      case (state_ff)
         mfb_pkg::ST_CLEAR:     ctl.sweep_we = 1'b1;
         mfb_pkg::ST_SET_WR:    ctl.pix_we = 1'b1;
         mfb_pkg::ST_GET_OUT:   ctl.get_rsp = 1'b1;
         mfb_pkg::ST_FILL: begin
            ctl.sweep_we   = 1'b1;
            ctl.sweep_fill = 1'b1;
         end
         mfb_pkg::ST_BLIT_LOAD: ctl.blit_load = 1'b1;
         mfb_pkg::ST_BLIT_RD:   ctl.rd_src = mfb_pkg::RD_BLIT;
         mfb_pkg::ST_BLIT_WR: begin
            ctl.rd_src  = mfb_pkg::RD_BLIT;
            ctl.blit_we = 1'b1;
         end
         mfb_pkg::ST_REF_RD:    ctl.rd_src = mfb_pkg::RD_REFRESH;
         mfb_pkg::ST_REF_OUT: begin
            ctl.rd_src  = mfb_pkg::RD_REFRESH;
            ctl.ref_rsp = 1'b1;
         end
         default: ;
      endcase
   end

   // the clearing pass holds the block off after every reset
   ap_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("block not busy after reset");

   // memory writes never overlap
   ap_one_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.pix_we, ctl.blit_we, ctl.sweep_we}))
      else $error("more than one memory write source");

   // no memory traffic or result while idle
   ap_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !(ctl.pix_we || ctl.blit_we || ctl.sweep_we || ctl.get_rsp || ctl.ref_rsp))
      else $error("datapath command issued while idle");

endmodule

FILE: rtl/mfb_datapath.sv
// Datapath: frame memory, pixel read-modify-write, blit cursor, refresh counters,
// control registers and the result register. Depends on mfb_pkg.
module mfb_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  mfb_pkg::req_type                  req_data,
   input  mfb_pkg::ctl_type                  ctl,
   input  logic                              csr_we,
   input  logic [mfb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [7:0]                        csr_wdata,
   output mfb_pkg::sts_type                  sts,
   output logic                              rsp_strobe,
   output mfb_pkg::rsp_type                  rsp_data
);

   localparam logic [mfb_pkg::FB_ADDR_W-1:0] SWEEP_LAST =
      mfb_pkg::FB_ADDR_W'(mfb_pkg::FB_BYTES - 1);
   localparam logic [mfb_pkg::COL_W-1:0] COL_LAST = mfb_pkg::COL_W'(mfb_pkg::PAGE_LEN - 1);
   localparam logic [mfb_pkg::PAGE_W-1:0] PAGE_LAST =
      mfb_pkg::PAGE_W'(mfb_pkg::PAGE_COUNT - 1);

   logic [7:0] frame_mem [mfb_pkg::FB_BYTES];
   logic [7:0] rd_data_ff;

   mfb_pkg::req_type req_ff;

   logic [7:0] page_base_ff, page_base_in;
   logic [7:0] lower_col_ff, lower_col_in;
   logic [7:0] upper_col_ff, upper_col_in;

   logic [6:0] origin_x_ff, origin_x_in;
   logic [5:0] origin_y_ff, origin_y_in;
   logic [7:0] span_w_ff, span_w_in;
   logic [6:0] span_h_ff, span_h_in;
   logic [7:0] col_off_ff, col_off_in;
   logic [6:0] row_off_ff, row_off_in;
   logic       blit_busy_ff, blit_busy_in;
   logic [2:0] bit_cnt_ff, bit_cnt_in;

   logic [mfb_pkg::FB_ADDR_W-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic [mfb_pkg::PAGE_W-1:0]    ref_page_ff, ref_page_in;
   logic [mfb_pkg::COL_W-1:0]     ref_col_ff, ref_col_in;

   logic             rsp_strobe_ff, rsp_strobe_in;
   mfb_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [mfb_pkg::FB_ADDR_W-1:0] pix_addr, blit_addr, ref_addr, rd_addr, wr_addr;
   logic       pix_on, blit_on, mem_we;
   logic [7:0] pix_mask, blit_mask, pix_byte, blit_byte, wr_data;
   logic [8:0] blit_x;
   logic [7:0] blit_y;
   logic       blit_bit, wrap, finish;
   logic [7:0] col_next;
   logic [6:0] row_next;
   logic       page_end, frame_end;
   logic [7:0] ref_byte;

   // ---------------- address and data generation ----------------
   always_comb begin
      pix_on   = int'(req_ff.y_pos) < mfb_pkg::SCREEN_HEIGHT;
      pix_addr = mfb_pkg::FB_ADDR_W'({req_ff.y_pos, req_ff.x_pos[6:3]});
      pix_mask = 8'h80 >> req_ff.x_pos[2:0];
      pix_byte = req_ff.pixel_value ? (rd_data_ff | pix_mask) : (rd_data_ff & ~pix_mask);

      blit_x    = {2'b00, origin_x_ff} + {1'b0, col_off_ff};
      blit_y    = {2'b00, origin_y_ff} + {1'b0, row_off_ff};
      blit_on   = (int'(blit_x) < mfb_pkg::SCREEN_WIDTH) &&
                  (int'(blit_y) < mfb_pkg::SCREEN_HEIGHT);
      blit_addr = mfb_pkg::FB_ADDR_W'({blit_y, blit_x[6:3]});
      blit_mask = 8'h80 >> blit_x[2:0];
      blit_bit  = req_ff.data_byte[~bit_cnt_ff];
      blit_byte = blit_bit ? (rd_data_ff | blit_mask) : (rd_data_ff & ~blit_mask);

      ref_addr = mfb_pkg::FB_ADDR_W'({ref_page_ff,
                 mfb_pkg::X_W'(ref_col_ff - mfb_pkg::COL_W'(mfb_pkg::HDR_LEN))});

      case (ctl.rd_src)
         mfb_pkg::RD_BLIT:    rd_addr = blit_addr;
         mfb_pkg::RD_REFRESH: rd_addr = ref_addr;
         default:             rd_addr = pix_addr;
      endcase

      mem_we = ctl.sweep_we || (ctl.pix_we && pix_on) || (ctl.blit_we && blit_on);
      if (ctl.sweep_we) begin
         wr_addr = sweep_cnt_ff;
         wr_data = {8{ctl.sweep_fill && req_ff.pixel_value}};
      end else if (ctl.blit_we) begin
         wr_addr = blit_addr;
         wr_data = blit_byte;
      end else begin
         wr_addr = pix_addr;
         wr_data = pix_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= frame_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.req_load) begin
         req_ff <= req_data;
      end
   end

   // ---------------- control registers ----------------
   always_comb begin
      page_base_in = page_base_ff;
      lower_col_in = lower_col_ff;
      upper_col_in = upper_col_ff;
      if (csr_we) begin
         case (csr_index)
            mfb_pkg::CSR_PAGE_BASE: page_base_in = csr_wdata;
            mfb_pkg::CSR_LOWER_COL: lower_col_in = csr_wdata;
            mfb_pkg::CSR_UPPER_COL: upper_col_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- blit cursor ----------------
   always_comb begin
      col_next = col_off_ff + 8'd1;
      row_next = row_off_ff + 7'd1;
      wrap     = (col_next == span_w_ff);
      finish   = wrap && (row_next == span_h_ff);

      origin_x_in  = origin_x_ff;
      origin_y_in  = origin_y_ff;
      span_w_in    = span_w_ff;
      span_h_in    = span_h_ff;
      col_off_in   = col_off_ff;
      row_off_in   = row_off_ff;
      blit_busy_in = blit_busy_ff;
      bit_cnt_in   = bit_cnt_ff;

      if (ctl.blit_load) begin
         origin_x_in  = req_ff.x_pos;
         origin_y_in  = req_ff.y_pos;
         span_w_in    = req_ff.blit_w;
         span_h_in    = req_ff.blit_h;
         col_off_in   = '0;
         row_off_in   = '0;
         blit_busy_in = (req_ff.blit_w != 8'd0) && (req_ff.blit_h != 7'd0);
      end else if (ctl.blit_we) begin
         if (wrap) begin
            col_off_in = '0;
            row_off_in = row_next;
            if (finish) blit_busy_in = 1'b0;
         end else begin
            col_off_in = col_next;
         end
      end

      if (ctl.req_load) begin
         bit_cnt_in = '0;
      end else if (ctl.blit_we) begin
         bit_cnt_in = bit_cnt_ff + 3'd1;
      end
   end

   // ---------------- sweep and refresh counters ----------------
   always_comb begin
      sweep_cnt_in = sweep_cnt_ff;
      if (ctl.sweep_we) begin
         sweep_cnt_in = (sweep_cnt_ff == SWEEP_LAST) ? '0 : sweep_cnt_ff + 1'b1;
      end

      page_end  = (ref_col_ff == COL_LAST);
      frame_end = page_end && (ref_page_ff == PAGE_LAST);
      ref_col_in  = ref_col_ff;
      ref_page_in = ref_page_ff;
      if (ctl.ref_rsp) begin
         if (page_end) begin
            ref_col_in  = '0;
            ref_page_in = (ref_page_ff == PAGE_LAST) ? '0 : ref_page_ff + 1'b1;
         end else begin
            ref_col_in = ref_col_ff + 1'b1;
         end
      end

      if (ref_col_ff == mfb_pkg::COL_W'(mfb_pkg::HDR_PAGE)) begin
         ref_byte = page_base_ff | 8'(ref_page_ff);
      end else if (ref_col_ff == mfb_pkg::COL_W'(mfb_pkg::HDR_LOW)) begin
         ref_byte = lower_col_ff;
      end else if (ref_col_ff == mfb_pkg::COL_W'(mfb_pkg::HDR_HIGH)) begin
         ref_byte = upper_col_ff;
      end else begin
         ref_byte = rd_data_ff;
      end
   end

   // ---------------- status to the controller ----------------
   always_comb begin
      sts.sweep_last  = (sweep_cnt_ff == SWEEP_LAST);
      sts.blit_active = blit_busy_ff;
      sts.blit_stop   = (bit_cnt_ff == 3'd7) || finish;
   end

   // ---------------- result register ----------------
   always_comb begin
      rsp_strobe_in = ctl.get_rsp || ctl.ref_rsp;
      rsp_data_in   = '0;
      if (ctl.ref_rsp) begin
         rsp_data_in.kind      = mfb_pkg::KIND_REFRESH;
         rsp_data_in.spi_byte  = ref_byte;
         rsp_data_in.is_data   = (ref_col_ff >= mfb_pkg::COL_W'(mfb_pkg::HDR_LEN));
         rsp_data_in.frame_end = frame_end;
      end else begin
         rsp_data_in.kind      = mfb_pkg::KIND_PIXEL;
         rsp_data_in.pixel_out = pix_on && rd_data_ff[~req_ff.x_pos[2:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_strobe_in) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_base_ff  <= mfb_pkg::PAGE_BASE_RST;
         lower_col_ff  <= mfb_pkg::LOWER_COL_RST;
         upper_col_ff  <= mfb_pkg::UPPER_COL_RST;
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
         span_w_ff     <= '0;
         span_h_ff     <= '0;
         col_off_ff    <= '0;
         row_off_ff    <= '0;
         blit_busy_ff  <= 1'b0;
         bit_cnt_ff    <= '0;
         sweep_cnt_ff  <= '0;
         ref_page_ff   <= '0;
         ref_col_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         page_base_ff  <= page_base_in;
         lower_col_ff  <= lower_col_in;
         upper_col_ff  <= upper_col_in;
         origin_x_ff   <= origin_x_in;
         origin_y_ff   <= origin_y_in;
         span_w_ff     <= span_w_in;
         span_h_ff     <= span_h_in;
         col_off_ff    <= col_off_in;
         row_off_ff    <= row_off_in;
         blit_busy_ff  <= blit_busy_in;
         bit_cnt_ff    <= bit_cnt_in;
         sweep_cnt_ff  <= sweep_cnt_in;
         ref_page_ff   <= ref_page_in;
         ref_col_ff    <= ref_col_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // every result-producing op passes through a read state before its output state, so strobes never touch
   ap_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("back-to-back result strobes");

   // cursor only advances inside an active blit
   ap_blit_live: assert property (@(posedge clock) disable iff (reset)
      ctl.blit_we |-> blit_busy_ff)
      else $error("blit write with no active blit");

   // refresh column stays within one page
   ap_ref_col: assert property (@(posedge clock) disable iff (reset)
      ref_col_ff <= COL_LAST)
      else $error("refresh column out of range");

endmodule

FILE: rtl/mono_framebuffer_blit_refresh_top.sv
// Monochrome framebuffer with pixel access, fill, bitmap blit and refresh streaming.
// Set pixel reads the byte, then writes it back; get pixel and render step read, then register a strobe;
// blit start loads the cursor; blit byte reads and writes each pixel, up to 8 per byte; fill sweeps all bytes.
// Per-item cost is set by the frame memory read-modify-write and fill sweep.
// Reset (synchronous) clears the 1024-byte store with busy held high.
// Results are one-cycle strobes; the receiver cannot stall. Uses mfb_pkg, mfb_ctrl, mfb_datapath.
module mono_framebuffer_blit_refresh_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  mfb_pkg::req_type              req_data,
   output logic                          rsp_strobe,
   output mfb_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [mfb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                    csr_wdata
);

   mfb_pkg::ctl_type ctl;
   mfb_pkg::sts_type sts;

   mfb_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_data.cmd),
      .sts     (sts),
      .busy    (busy),
      .ctl     (ctl)
   );

   mfb_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .ctl        (ctl),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for mono_framebuffer_blit_refresh_top: pixel access, fill, blit, refresh.
// A queue-fed driver and a clocked monitor check results against a behavioral framebuffer.
// Depends on mfb_pkg and the block's RTL only.
module tb_top;
   import mfb_pkg::*;

   localparam int HALF_PERIOD    = 4;
   localparam int REQ_BITS       = $bits(req_type);
   localparam int FRAME_LEN      = PAGE_COUNT * PAGE_LEN;
   localparam int SETTLE_CYCLES  = 1100;   // covers a fill sweep
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PAUSE_EVERY    = 60;

   // codes the block must ignore
   localparam logic [2:0] CMD_SPARE_A = 3'd6;
   localparam logic [2:0] CMD_SPARE_B = 3'd7;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_data;
   logic                 rsp_strobe;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [7:0]           csr_wdata;

   mono_framebuffer_blit_refresh_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // display model state
   logic [7:0]  fb_mirror [FB_BYTES];
   logic [6:0]  blit_x0;
   logic [5:0]  blit_y0;
   logic [7:0]  blit_wd;
   logic [6:0]  blit_ht;
   logic [7:0]  blit_col;
   logic [6:0]  blit_row;
   logic        blit_active;
   logic [10:0] stream_pos;
   logic [7:0]  pg_cmd_base = PAGE_BASE_RST;
   logic [7:0]  col_lo_cmd  = LOWER_COL_RST;
   logic [7:0]  col_hi_cmd  = UPPER_COL_RST;

   req_type cmd_q [$];
   rsp_type predicted_out_q [$];
   int      items_in_flight = 0;
   int      idle_pct = 23;
   int      err_count = 0;
   int      quiet_cycles = 0;
   logic    req_taken;

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   function automatic req_type noise_req();
      return req_type'(REQ_BITS'({$urandom, $urandom}));
   endfunction

   function automatic void write_pixel(input int x, input int y, input logic v);
      int pos;
      if (x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT) return;
      pos = (y * SCREEN_WIDTH + x) / 8;
      fb_mirror[pos][7 - x % 8] = v;
   endfunction

   // advance the model by one accepted command; queue the answer if it gives one
   function automatic void emulate_display(input req_type r);
      rsp_type o;
      int      page, slot, bit_i;
      o = '0;
      case (r.cmd)
         CMD_SET_PIXEL: write_pixel(r.x_pos, r.y_pos, r.pixel_value);
         CMD_GET_PIXEL: begin
            o.kind      = KIND_PIXEL;
            o.pixel_out = fb_mirror[(int'(r.y_pos) * SCREEN_WIDTH + r.x_pos) / 8][7 - r.x_pos % 8];
            predicted_out_q.push_back(o);
         end
         CMD_FILL: foreach (fb_mirror[i]) fb_mirror[i] = {8{r.pixel_value}};
         CMD_BLIT_START: begin
            blit_x0     = r.x_pos;
            blit_y0     = r.y_pos;
            blit_wd     = r.blit_w;
            blit_ht     = r.blit_h;
            blit_col    = '0;
            blit_row    = '0;
            blit_active = (r.blit_w != 0) && (r.blit_h != 0);
         end
         CMD_BLIT_BYTE: begin
            // cursor moves even for dropped pixels; the blit may end mid-byte
            for (bit_i = 0; bit_i < 8 && blit_active; bit_i++) begin
               write_pixel(int'(blit_x0) + int'(blit_col), int'(blit_y0) + int'(blit_row),
                           r.data_byte[7 - bit_i]);
               blit_col++;
               if (blit_col == blit_wd) begin
                  blit_col = '0;
                  blit_row++;
                  if (blit_row == blit_ht) blit_active = 1'b0;
               end
            end
         end
         CMD_RENDER: begin
            page   = stream_pos / PAGE_LEN;
            slot   = stream_pos % PAGE_LEN;
            o.kind = KIND_REFRESH;
            if (slot == HDR_PAGE) o.spi_byte = pg_cmd_base | 8'(page);
            else if (slot == HDR_LOW) o.spi_byte = col_lo_cmd;
            else if (slot == HDR_HIGH) o.spi_byte = col_hi_cmd;
            else begin
               o.spi_byte = fb_mirror[page * SCREEN_WIDTH + slot - HDR_LEN];
               o.is_data  = 1'b1;
            end
            o.frame_end = (stream_pos == FRAME_LEN - 1);
            stream_pos  = o.frame_end ? '0 : stream_pos + 1'b1;
            predicted_out_q.push_back(o);
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         err_count++;
      end
   endfunction

   // driver: a held transfer stays on the bus until the block takes it
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !req_taken) begin
      end else if (cmd_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
         req_data <= cmd_q.pop_front();
         start    <= 1'b1;
      end else begin
         req_data <= noise_req();
         start    <= 1'b0;
      end
   end

   // monitor: check results, then predict from the transfer at this edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= start && !busy;
         if (rsp_strobe) begin
            if (predicted_out_q.size() == 0) begin
               $error("unexpected result: kind %0b spi_byte %0h", rsp_data.kind, rsp_data.spi_byte);
               err_count++;
            end else begin
               want = predicted_out_q.pop_front();
               check_field("kind", want.kind, rsp_data.kind);
               check_field("pixel_out", want.pixel_out, rsp_data.pixel_out);
               check_field("spi_byte", want.spi_byte, rsp_data.spi_byte);
               check_field("is_data", want.is_data, rsp_data.is_data);
               check_field("frame_end", want.frame_end, rsp_data.frame_end);
            end
         end
         if (start && !busy) begin
            emulate_display(req_data);
            items_in_flight--;
         end
         if ((start && !busy) || rsp_strobe) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic queue_cmd(input logic [2:0] op, input int x, input int y, input int v,
                            input int w, input int h, input int d);
      req_type r;
      r             = noise_req();
      r.cmd         = op;
      r.x_pos       = 7'(x);
      r.y_pos       = 6'(y);
      r.pixel_value = 1'(v);
      r.blit_w      = 8'(w);
      r.blit_h      = 7'(h);
      r.data_byte   = 8'(d);
      cmd_q.push_back(r);
      items_in_flight++;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (items_in_flight != 0 || predicted_out_q.size() != 0);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_PAGE_BASE: pg_cmd_base = value;
         CSR_LOWER_COL: col_lo_cmd  = value;
         CSR_UPPER_COL: col_hi_cmd  = value;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_display_regs(input logic [7:0] base, input logic [7:0] lo,
                                   input logic [7:0] hi);
      write_csr(CSR_PAGE_BASE, base);
      write_csr(CSR_LOWER_COL, lo);
      write_csr(CSR_UPPER_COL, hi);
   endtask

   // mostly complete blit sequences, with pixel traffic aimed near the last blit
   task automatic queue_random(input int count);
      int made, pause_at, sel, shape, w, h, x0, y0, nbytes, hot_x, hot_y, px, py;
      made     = 0;
      pause_at = PAUSE_EVERY;
      hot_x    = $urandom_range(127);
      hot_y    = $urandom_range(63);
      while (made < count) begin
         sel = $urandom_range(99);
         if ($urandom_range(1)) begin
            px = hot_x + $urandom_range(15);
            py = hot_y + $urandom_range(7);
         end else begin
            px = $urandom_range(127);
            py = $urandom_range(63);
         end
         if (sel < 30) begin
            shape = $urandom_range(9);
            w     = $urandom_range(1, 16);
            h     = $urandom_range(1, 8);
            if (shape == 0) begin
               w = $urandom_range(128, 255);
               h = $urandom_range(1, 2);
            end else if (shape == 1) begin
               w = $urandom_range(1, 3);
               h = $urandom_range(64, 127);
            end else if (shape == 2) begin
               if ($urandom_range(1)) w = 0;
               else h = 0;
            end
            if ($urandom_range(1)) begin
               x0 = $urandom_range(127);
               y0 = $urandom_range(63);
            end else begin
               x0 = $urandom_range(110, 127);
               y0 = $urandom_range(52, 63);
            end
            hot_x  = x0;
            hot_y  = y0;
            nbytes = (w * h + 7) / 8;
            if (shape == 2) nbytes = $urandom_range(0, 2);
            else if (shape == 3) nbytes = $urandom_range(0, nbytes);   // cut short by a restart
            else if (shape == 4) nbytes += $urandom_range(1, 3);       // trailing bytes ignored
            queue_cmd(CMD_BLIT_START, x0, y0, $urandom, w, h, $urandom);
            repeat (nbytes)
               queue_cmd(CMD_BLIT_BYTE, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom);
            made += nbytes + 1;
         end else if (sel < 48) begin
            queue_cmd(CMD_SET_PIXEL, px, py, $urandom, $urandom, $urandom, $urandom);
            made++;
         end else if (sel < 68) begin
            queue_cmd(CMD_GET_PIXEL, px, py, $urandom, $urandom, $urandom, $urandom);
            made++;
         end else if (sel < 94) begin
            repeat ($urandom_range(1, 6)) begin
               queue_cmd(CMD_RENDER, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom);
               made++;
            end
         end else if (sel < 96) begin
            queue_cmd(CMD_FILL, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            made++;
         end else begin
            queue_cmd($urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
         end
         // sender holds off until every answer is back
         if (made >= pause_at) begin
            wait_drained();
            pause_at += PAUSE_EVERY;
         end
      end
   endtask

   task automatic run_phase(input int idle, input int count, input logic [7:0] base,
                            input logic [7:0] lo, input logic [7:0] hi);
      set_display_regs(base, lo, hi);
      idle_pct = idle;
      queue_random(count);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      foreach (fb_mirror[i]) fb_mirror[i] = '0;
      blit_x0     = '0;
      blit_y0     = '0;
      blit_wd     = '0;
      blit_ht     = '0;
      blit_col    = '0;
      blit_row    = '0;
      blit_active = 1'b0;
      stream_pos  = '0;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      // store is cleared after reset with busy high
      do @(negedge clock);
      while (busy);

      set_display_regs(PAGE_BASE_RST, LOWER_COL_RST, UPPER_COL_RST);
      idle_pct = 23;
      queue_cmd(CMD_GET_PIXEL, 127, 63, 0, 0, 0, 0);
      queue_cmd(CMD_SET_PIXEL, 0, 0, 1, 0, 0, 0);
      queue_cmd(CMD_SET_PIXEL, 127, 63, 1, 0, 0, 0);
      queue_cmd(CMD_GET_PIXEL, 0, 0, 0, 0, 0, 0);
      queue_cmd(CMD_GET_PIXEL, 127, 63, 0, 0, 0, 0);
      queue_cmd(CMD_SET_PIXEL, 127, 63, 0, 255, 127, 255);
      queue_cmd(CMD_GET_PIXEL, 127, 63, 1, 255, 127, 255);
      queue_cmd(CMD_FILL, 0, 0, 1, 0, 0, 0);
      queue_cmd(CMD_RENDER, 0, 0, 0, 0, 0, 0);
      queue_cmd(CMD_RENDER, 0, 0, 0, 0, 0, 0);
      queue_cmd(CMD_RENDER, 0, 0, 0, 0, 0, 0);
      queue_cmd(CMD_RENDER, 0, 0, 0, 0, 0, 0);
      queue_cmd(CMD_FILL, 0, 0, 0, 0, 0, 0);
      // blit hanging off the right and bottom edges, exact end, then an ignored byte
      queue_cmd(CMD_BLIT_START, 124, 62, 0, 8, 3, 0);
      queue_cmd(CMD_BLIT_BYTE, 0, 0, 0, 0, 0, 8'hFF);
      queue_cmd(CMD_BLIT_BYTE, 0, 0, 0, 0, 0, 8'hA5);
      queue_cmd(CMD_BLIT_BYTE, 0, 0, 0, 0, 0, 8'h3C);
      queue_cmd(CMD_BLIT_BYTE, 0, 0, 0, 0, 0, 8'hFF);
      queue_cmd(CMD_GET_PIXEL, 125, 63, 0, 0, 0, 0);
      queue_cmd(CMD_BLIT_START, 0, 0, 0, 0, 5, 0);
      queue_cmd(CMD_BLIT_BYTE, 0, 0, 0, 0, 0, 8'hFF);
      // restart while busy, then a blit ending mid-byte
      queue_cmd(CMD_BLIT_START, 10, 10, 0, 128, 64, 0);
      queue_cmd(CMD_BLIT_BYTE, 0, 0, 0, 0, 0, 8'hF0);
      queue_cmd(CMD_BLIT_START, 0, 1, 0, 3, 1, 0);
      queue_cmd(CMD_BLIT_BYTE, 0, 0, 0, 0, 0, 8'hFF);
      queue_cmd(CMD_GET_PIXEL, 3, 1, 0, 0, 0, 0);
      queue_cmd(CMD_GET_PIXEL, 10, 10, 0, 0, 0, 0);
      queue_cmd(CMD_SPARE_A, 0, 0, 0, 0, 0, 0);
      queue_cmd(CMD_SPARE_B, 127, 63, 1, 255, 127, 255);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);

      run_phase(23, 180, 8'h00, 8'hFF, 8'h00);
      run_phase(85, 180, 8'hFF, 8'h00, 8'hFF);
      run_phase(0, 180, 8'($urandom), 8'($urandom), 8'($urandom));

      // a full refresh frame and its wrap
      set_display_regs(8'($urandom), 8'($urandom), 8'($urandom));
      idle_pct = 0;
      repeat (FRAME_LEN + 12)
         queue_cmd(CMD_RENDER, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/mfb_pkg.sv
rtl/mfb_ctrl.sv
rtl/mfb_datapath.sv
rtl/mono_framebuffer_blit_refresh_top.sv
test/tb_top.sv
